// File: rtl/bounded_array_deque_defines.svh
// assertion macros used by the port-level checker
`ifndef BOUNDED_ARRAY_DEQUE_DEFINES_SVH
`define BOUNDED_ARRAY_DEQUE_DEFINES_SVH

// same-cycle implication, muted while reset is low
`define BAD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, also checked during reset
`define BAD_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: rtl/bad_pkg.sv
// shared constants, codes and types of the bounded array deque
package bad_pkg;

    localparam int DEPTH  = 256;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;

    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BACK_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FRONT_FULL = 2'd3;

    localparam logic [IDX_W-1:0] IDX_START = IDX_W'(DEPTH / 2 - 1);
    localparam logic [IDX_W-1:0] IDX_TOP   = IDX_W'(DEPTH - 1);

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] popped;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
    } result_t;

endpackage

// File: rtl/bad_store.sv
// slot store: one write port, one read port with registered read data
module bad_store (
    input  logic                              aclk,
    input  bad_pkg::wr_req_t                  wr,
    input  logic                              rd_en,
    input  logic [bad_pkg::IDX_W-1:0]         rd_addr,
    output logic signed [bad_pkg::DATA_W-1:0] rd_data
);
    import bad_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/bounded_array_deque.sv
// top level of the bounded array deque: control, end-value cache and output stage
// result path: pushes, inspects, failed pops and pops that leave at most one entry go
//   straight into the output stage; a pop that leaves two or more entries first waits
//   in the pending register for the registered read of the new end slot from the slot store
// throughput: one item per cycle while the skid slot is free; no new item during those reads
// reset: synchronous active-low aresetn returns both indices to the middle slot and the
//   count to zero; the slot store is not cleared, no slot is read before it is written
module bounded_array_deque (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bad_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [bad_pkg::DATA_W-1:0]   s_data_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bad_pkg::STAT_W-1:0]          m_status,
    output logic signed [bad_pkg::DATA_W-1:0]   m_popped_value,
    output logic [bad_pkg::CNT_W-1:0]           m_entry_count,
    output logic signed [bad_pkg::DATA_W-1:0]   m_front_value,
    output logic signed [bad_pkg::DATA_W-1:0]   m_back_value
);
    import bad_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // control state
    logic             state_reg, state_next;
    logic [IDX_W-1:0] front_idx_reg, front_idx_next;
    logic [IDX_W-1:0] back_idx_reg, back_idx_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    // cached values at both ends, valid while the deque is not empty
    logic signed [DATA_W-1:0] front_val_reg, front_val_next;
    logic signed [DATA_W-1:0] back_val_reg, back_val_next;

    // result waiting for the slot read, and which end the read refills
    result_t pend_reg, pend_next;
    logic    pend_back_reg, pend_back_next;

    // two-entry output stage: main register plus skid
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    wr_req_t                  wr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    logic    s_fire;
    logic    m_fire;
    logic    push;
    result_t push_res;
    result_t now_res;

    bad_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // take a new item only between operations and while the skid slot is free
    assign s_ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = main_valid_reg && m_ready;

    // operation decode, executed on the input transfer
    always_comb begin
        state_next     = state_reg;
        front_idx_next = front_idx_reg;
        back_idx_next  = back_idx_reg;
        occ_next       = occ_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        pend_next      = pend_reg;
        pend_back_next = pend_back_reg;
        wr             = '{en: 1'b0, addr: back_idx_reg, data: s_data_in};
        rd_en          = 1'b0;
        rd_addr        = back_idx_reg;
        now_res        = '0;
        push           = 1'b0;
        push_res       = '0;

        if (state_reg == ST_READ) begin
            // slot data is back: refill the cached end and hand off the result
            push_res = pend_reg;
            if (pend_back_reg) begin
                back_val_next = rd_data;
                push_res.back = rd_data;
            end else begin
                front_val_next = rd_data;
                push_res.front = rd_data;
            end
            push       = 1'b1;
            state_next = ST_IDLE;
        end else if (s_fire) begin
            now_res.status = STAT_OK;
            unique case (s_func)
                FUNC_PUSH_BACK: begin
                    if (occ_reg == '0) begin
                        // empty deque writes at the shared slot
                        wr             = '{en: 1'b1, addr: back_idx_reg, data: s_data_in};
                        occ_next       = CNT_W'(1);
                        front_val_next = s_data_in;
                        back_val_next  = s_data_in;
                    end else if (back_idx_reg == IDX_TOP) begin
                        now_res.status = STAT_BACK_FULL;
                    end else begin
                        back_idx_next = back_idx_reg + IDX_W'(1);
                        wr            = '{en: 1'b1, addr: back_idx_next, data: s_data_in};
                        occ_next      = occ_reg + CNT_W'(1);
                        back_val_next = s_data_in;
                    end
                end
                FUNC_PUSH_FRONT: begin
                    if (occ_reg == '0) begin
                        wr             = '{en: 1'b1, addr: front_idx_reg, data: s_data_in};
                        occ_next       = CNT_W'(1);
                        front_val_next = s_data_in;
                        back_val_next  = s_data_in;
                    end else if (front_idx_reg == '0) begin
                        now_res.status = STAT_FRONT_FULL;
                    end else begin
                        front_idx_next = front_idx_reg - IDX_W'(1);
                        wr             = '{en: 1'b1, addr: front_idx_next, data: s_data_in};
                        occ_next       = occ_reg + CNT_W'(1);
                        front_val_next = s_data_in;
                    end
                end
                FUNC_POP_BACK: begin
                    if (occ_reg == '0) begin
                        now_res.status = STAT_EMPTY;
                    end else begin
                        now_res.popped = back_val_reg;
                        occ_next       = occ_reg - CNT_W'(1);
                        if (back_idx_reg != front_idx_reg) begin
                            back_idx_next = back_idx_reg - IDX_W'(1);
                        end
                        if (occ_reg == CNT_W'(2)) begin
                            // the front entry becomes the back as well
                            back_val_next = front_val_reg;
                        end else if (occ_reg > CNT_W'(2)) begin
                            rd_en          = 1'b1;
                            rd_addr        = back_idx_next;
                            pend_back_next = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                end
                FUNC_POP_FRONT: begin
                    if (occ_reg == '0) begin
                        now_res.status = STAT_EMPTY;
                    end else begin
                        now_res.popped = front_val_reg;
                        occ_next       = occ_reg - CNT_W'(1);
                        if (back_idx_reg != front_idx_reg) begin
                            front_idx_next = front_idx_reg + IDX_W'(1);
                        end
                        if (occ_reg == CNT_W'(2)) begin
                            front_val_next = back_val_reg;
                        end else if (occ_reg > CNT_W'(2)) begin
                            rd_en          = 1'b1;
                            rd_addr        = front_idx_next;
                            pend_back_next = 1'b0;
                            state_next     = ST_READ;
                        end
                    end
                end
                default: begin
                    // inspect only, taken by all codes other than the four operations
                end
            endcase

            now_res.count = occ_next;
            // empty deque reports zero at both ends
            now_res.front = (occ_next == '0) ? '0 : front_val_next;
            now_res.back  = (occ_next == '0) ? '0 : back_val_next;

            if (state_next == ST_READ) begin
                pend_next = now_res;
            end else begin
                push     = 1'b1;
                push_res = now_res;
            end
        end
    end

    // output stage: skid drains into main first, new results queue behind it
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || m_fire) begin
            main_next       = skid_valid_reg ? skid_reg : push_res;
            main_valid_next = skid_valid_reg || push;
            skid_next       = push_res;
            skid_valid_next = skid_valid_reg && push;
        end else if (push) begin
            skid_next       = push_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            front_idx_reg  <= IDX_START;
            back_idx_reg   <= IDX_START;
            occ_reg        <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            front_idx_reg  <= front_idx_next;
            back_idx_reg   <= back_idx_next;
            occ_reg        <= occ_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        pend_reg      <= pend_next;
        pend_back_reg <= pend_back_next;
        main_reg      <= main_next;
        skid_reg      <= skid_next;
    end

    assign m_valid        = main_valid_reg;
    assign m_status       = main_reg.status;
    assign m_popped_value = main_reg.popped;
    assign m_entry_count  = main_reg.count;
    assign m_front_value  = main_reg.front;
    assign m_back_value   = main_reg.back;

endmodule

// File: rtl/bad_checker.sv
// port-level checker of the bounded array deque and its bind
`include "bounded_array_deque_defines.svh"

module bad_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic [bad_pkg::STAT_W-1:0]          m_status,
    input logic signed [bad_pkg::DATA_W-1:0]   m_popped_value,
    input logic [bad_pkg::CNT_W-1:0]           m_entry_count,
    input logic signed [bad_pkg::DATA_W-1:0]   m_front_value,
    input logic signed [bad_pkg::DATA_W-1:0]   m_back_value
);
    import bad_pkg::*;

    // no result shows right after reset
    `BAD_ASSERT_NEXT(a_reset_clears, aclk, !aresetn, !m_valid)

    // a failed pop only happens on an empty deque and removes nothing
    `BAD_ASSERT_NOW(a_empty_pop, aclk, aresetn, m_valid && (m_status == STAT_EMPTY), (m_entry_count == '0) && (m_popped_value == '0))

    // an empty deque shows zero at both ends
    `BAD_ASSERT_NOW(a_empty_ends, aclk, aresetn, m_valid && (m_entry_count == '0), (m_front_value == '0) && (m_back_value == '0))

    // a failed push leaves entries behind and pops nothing
    `BAD_ASSERT_NOW(a_full_push, aclk, aresetn, m_valid && ((m_status == STAT_BACK_FULL) || (m_status == STAT_FRONT_FULL)), (m_entry_count != '0) && (m_popped_value == '0))

endmodule

bind bounded_array_deque bad_checker u_bad_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_status       (m_status),
    .m_popped_value (m_popped_value),
    .m_entry_count  (m_entry_count),
    .m_front_value  (m_front_value),
    .m_back_value   (m_back_value)
);
